### sv/rasmr_pkg.sv
// rasmr_pkg: shared constants, codes and controller/datapath interface types
// for the rational add/sub/multiply block with gcd reduction
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rasmr_pkg;

  // default operand width and fixed result field widths
  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int OP_W              = 2;
  localparam int NUM_OUT_W         = 33;
  localparam int DEN_OUT_W         = 31;
  localparam int OUT_DATA_W        = 64;

  // operation codes (any other code multiplies)
  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  // which pair the reduction unit works on
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_R
  } red_sel_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MS_T0,
    MS_T1,
    MS_DEN
  } mul_sel_t;

  // where the registered product is captured
  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_T0,
    CAP_T1,
    CAP_DEN
  } cap_t;

  // controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     red_start;
    red_sel_t red_sel;
    logic     wb;
    mul_sel_t mul_sel;
    cap_t     cap;
    logic     comb;
    logic     out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic red_done;
  } sts_t;

endpackage

`default_nettype wire

### sv/rasmr_reduce.sv
// rasmr_reduce: iterative reduction unit, binary gcd one step a cycle followed
// by two restoring divisions by the gcd, one quotient bit a cycle
// depends on rasmr_pkg (house style only, no shared types used)
`timescale 1ns / 1ps
`default_nettype none

module rasmr_reduce #(
  parameter int MAG_W = 2 * rasmr_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [MAG_W-1:0] x_in,   // numerator magnitude
  input  wire logic [MAG_W-1:0] y_in,   // denominator, never zero
  output logic                  done,
  output logic      [MAG_W-1:0] q_num,
  output logic      [MAG_W-1:0] q_den
);

  localparam int KW = $clog2(MAG_W);

  typedef enum logic [1:0] {
    R_IDLE,
    R_GCD,
    R_DIV,
    R_DONE
  } r_state_t;

  r_state_t         state_r, state_nxt;
  logic [MAG_W-1:0] nx_r, nx_nxt, ny_r, ny_nxt;
  logic [MAG_W-1:0] gx_r, gx_nxt, gy_r, gy_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic [KW-1:0]    cnt_r, cnt_nxt;
  logic [MAG_W-1:0] d_r, d_nxt;
  logic [MAG_W-1:0] rn_r, rn_nxt, rd_r, rd_nxt;
  logic [MAG_W-1:0] qn_r, qn_nxt, qd_r, qd_nxt;
  logic [MAG_W:0]   trial_n, trial_d;
  logic             gx_ge;

  // one division bit for each dividend
  assign trial_n = {rn_r, qn_r[MAG_W-1]};
  assign trial_d = {rd_r, qd_r[MAG_W-1]};
  assign gx_ge   = (gx_r >= gy_r);

  // next state and datapath of the unit
  always_comb begin
    state_nxt = state_r;
    nx_nxt    = nx_r;
    ny_nxt    = ny_r;
    gx_nxt    = gx_r;
    gy_nxt    = gy_r;
    k_nxt     = k_r;
    cnt_nxt   = cnt_r;
    d_nxt     = d_r;
    rn_nxt    = rn_r;
    rd_nxt    = rd_r;
    qn_nxt    = qn_r;
    qd_nxt    = qd_r;
    case (state_r)
      R_IDLE: begin
        if (start) begin
          nx_nxt = x_in;
          ny_nxt = y_in;
          gx_nxt = x_in;
          gy_nxt = y_in;
          k_nxt  = '0;
          qn_nxt = x_in;
          qd_nxt = y_in;
          // zero numerator is left as it is
          state_nxt = (x_in == '0) ? R_DONE : R_GCD;
        end
      end
      R_GCD: begin
        if (gx_r == '0) begin
          // gcd is gy << k; divide the dividends pre-shifted by k by gy
          d_nxt   = gy_r;
          rn_nxt  = '0;
          rd_nxt  = '0;
          qn_nxt  = nx_r >> k_r;
          qd_nxt  = ny_r >> k_r;
          cnt_nxt = KW'(MAG_W - 1);
          if (gy_r == MAG_W'(1) && k_r == '0) begin
            qn_nxt    = nx_r;
            qd_nxt    = ny_r;
            state_nxt = R_DONE;
          end else begin
            state_nxt = R_DIV;
          end
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          k_nxt  = k_r + KW'(1);
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_ge) begin
          gx_nxt = (gx_r - gy_r) >> 1;
        end else begin
          gy_nxt = (gy_r - gx_r) >> 1;
        end
      end
      R_DIV: begin
        if (trial_n >= {1'b0, d_r}) begin
          rn_nxt = MAG_W'(trial_n - {1'b0, d_r});
          qn_nxt = {qn_r[MAG_W-2:0], 1'b1};
        end else begin
          rn_nxt = trial_n[MAG_W-1:0];
          qn_nxt = {qn_r[MAG_W-2:0], 1'b0};
        end
        if (trial_d >= {1'b0, d_r}) begin
          rd_nxt = MAG_W'(trial_d - {1'b0, d_r});
          qd_nxt = {qd_r[MAG_W-2:0], 1'b1};
        end else begin
          rd_nxt = trial_d[MAG_W-1:0];
          qd_nxt = {qd_r[MAG_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - KW'(1);
        if (cnt_r == '0) begin
          state_nxt = R_DONE;
        end
      end
      R_DONE: begin
        state_nxt = R_IDLE;
      end
      default: begin
        state_nxt = R_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    gx_r  <= gx_nxt;
    gy_r  <= gy_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    d_r   <= d_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
  end

  assign done  = (state_r == R_DONE);
  assign q_num = qn_r;
  assign q_den = qd_r;

endmodule

`default_nettype wire

### sv/rasmr_dp.sv
// rasmr_dp: datapath, operand normalisation, shared multiplier, sign
// combination, reduction unit and result register
// depends on rasmr_pkg and rasmr_reduce
`timescale 1ns / 1ps
`default_nettype none

module rasmr_dp #(
  parameter int OPERAND_WIDTH = rasmr_pkg::OPERAND_WIDTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire rasmr_pkg::cmd_t                    cmd,
  output rasmr_pkg::sts_t                         sts,
  input  wire logic [rasmr_pkg::OP_W-1:0]         operation,
  input  wire logic signed [OPERAND_WIDTH-1:0]    a_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]    a_denominator,
  input  wire logic signed [OPERAND_WIDTH-1:0]    b_numerator,
  input  wire logic signed [OPERAND_WIDTH-1:0]    b_denominator,
  output logic signed [rasmr_pkg::NUM_OUT_W-1:0]  result_numerator,
  output logic        [rasmr_pkg::DEN_OUT_W-1:0]  result_denominator
);

  import rasmr_pkg::*;

  localparam int W     = OPERAND_WIDTH;
  localparam int M     = 2 * OPERAND_WIDTH;
  localparam int NEXT  = (M + 1 > NUM_OUT_W) ? M + 1 : NUM_OUT_W;
  localparam int DEXT  = (M > DEN_OUT_W) ? M : DEN_OUT_W;

  logic [OP_W-1:0] op_r;
  logic [W-1:0]    an_r, ad_r, bn_r, bd_r;
  logic            an_neg_r, bn_neg_r;
  logic [M-1:0]    p_r, t0_r, t1_r;
  logic [M-1:0]    rn_r, rd_r;
  logic            rn_neg_r;
  logic signed [NUM_OUT_W-1:0] out_num_r;
  logic [DEN_OUT_W-1:0]        out_den_r;

  logic [W-1:0]    an_abs, ad_abs, bn_abs, bd_abs;
  logic [W-1:0]    mul_a, mul_b;
  logic [M-1:0]    red_x, red_y, q_num, q_den;
  logic            red_done;
  logic            s1, s2;
  logic [M-1:0]    comb_mag;
  logic            comb_neg;
  logic [NEXT-1:0] num_ext, num_sgn;
  logic [DEXT-1:0] den_ext;

  // operand magnitudes: zero denominator reads as one
  assign an_abs = a_numerator[W-1] ? W'(-a_numerator) : W'(a_numerator);
  assign bn_abs = b_numerator[W-1] ? W'(-b_numerator) : W'(b_numerator);
  assign ad_abs = a_denominator[W-1] ? W'(-a_denominator) :
                  (a_denominator == '0) ? W'(1) : W'(a_denominator);
  assign bd_abs = b_denominator[W-1] ? W'(-b_denominator) :
                  (b_denominator == '0) ? W'(1) : W'(b_denominator);

  // multiplier operand selection
  always_comb begin
    case (cmd.mul_sel)
      MS_T0: begin
        mul_a = an_r;
        mul_b = (op_r == OP_ADD || op_r == OP_SUB) ? bd_r : bn_r;
      end
      MS_T1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      MS_DEN: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  // signed sum or difference of the two cross products, or for a multiply the single product
  always_comb begin
    s1 = an_neg_r;
    s2 = bn_neg_r ^ (op_r == OP_SUB);
    if (!(op_r == OP_ADD || op_r == OP_SUB)) begin
      comb_mag = t0_r;
      comb_neg = an_neg_r ^ bn_neg_r;
    end else if (s1 == s2) begin
      comb_mag = t0_r + t1_r;
      comb_neg = s1;
    end else if (t0_r >= t1_r) begin
      comb_mag = t0_r - t1_r;
      comb_neg = s1;
    end else begin
      comb_mag = t1_r - t0_r;
      comb_neg = s2;
    end
  end

  // reduction unit operand selection
  always_comb begin
    case (cmd.red_sel)
      SEL_A: begin
        red_x = M'(an_r);
        red_y = M'(ad_r);
      end
      SEL_B: begin
        red_x = M'(bn_r);
        red_y = M'(bd_r);
      end
      SEL_R: begin
        red_x = rn_r;
        red_y = rd_r;
      end
      default: begin
        red_x = rn_r;
        red_y = rd_r;
      end
    endcase
  end

  rasmr_reduce #(
    .MAG_W (M)
  ) u_reduce (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.red_start),
    .x_in  (red_x),
    .y_in  (red_y),
    .done  (red_done),
    .q_num (q_num),
    .q_den (q_den)
  );

  assign sts.red_done = red_done;

  // signed result, truncated to the output fields
  assign num_ext = NEXT'(rn_r);
  assign num_sgn = rn_neg_r ? (~num_ext + NEXT'(1)) : num_ext;
  assign den_ext = DEXT'(rd_r);

  // operand, product and result registers
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    if (cmd.load) begin
      op_r     <= operation;
      an_r     <= an_abs;
      ad_r     <= ad_abs;
      bn_r     <= bn_abs;
      bd_r     <= bd_abs;
      an_neg_r <= a_numerator[W-1] ^ a_denominator[W-1];
      bn_neg_r <= b_numerator[W-1] ^ b_denominator[W-1];
    end
    if (cmd.wb) begin
      case (cmd.red_sel)
        SEL_A: begin
          an_r <= q_num[W-1:0];
          ad_r <= q_den[W-1:0];
        end
        SEL_B: begin
          bn_r <= q_num[W-1:0];
          bd_r <= q_den[W-1:0];
        end
        SEL_R: begin
          rn_r <= q_num;
          rd_r <= q_den;
        end
        default: begin
          rn_r <= q_num;
          rd_r <= q_den;
        end
      endcase
    end
    case (cmd.cap)
      CAP_NONE: begin
      end
      CAP_T0: begin
        t0_r <= p_r;
      end
      CAP_T1: begin
        t1_r <= p_r;
      end
      CAP_DEN: begin
        rd_r <= p_r;
      end
      default: begin
      end
    endcase
    if (cmd.comb) begin
      rn_r     <= comb_mag;
      rn_neg_r <= comb_neg;
    end
    if (cmd.out_load) begin
      out_num_r <= signed'(num_sgn[NUM_OUT_W-1:0]);
      out_den_r <= den_ext[DEN_OUT_W-1:0];
    end
  end

  assign result_numerator   = out_num_r;
  assign result_denominator = out_den_r;

endmodule

`default_nettype wire

### sv/rasmr_ctrl.sv
// rasmr_ctrl: sequencing state machine, drives datapath commands and the
// input ready and output valid handshake signals
// depends on rasmr_pkg
`timescale 1ns / 1ps
`default_nettype none

module rasmr_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  wire logic            out_tready,
  output rasmr_pkg::cmd_t      cmd,
  input  wire rasmr_pkg::sts_t sts
);

  import rasmr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RA_GO,
    S_RA_WAIT,
    S_RB_GO,
    S_RB_WAIT,
    S_M0,
    S_M1,
    S_M2,
    S_M3,
    S_COMB,
    S_RR_GO,
    S_RR_WAIT,
    S_OUT
  } c_state_t;

  c_state_t state_r, state_nxt;
  logic     out_valid_r, out_valid_nxt;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.red_sel   = SEL_R;
    cmd.mul_sel   = MS_DEN;
    cmd.cap       = CAP_NONE;
    out_valid_nxt = (out_valid_r && out_tready) ? 1'b0 : out_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RA_GO;
        end
      end
      S_RA_GO: begin
        cmd.red_start = 1'b1;
        cmd.red_sel   = SEL_A;
        state_nxt     = S_RA_WAIT;
      end
      S_RA_WAIT: begin
        cmd.red_sel = SEL_A;
        if (sts.red_done) begin
          cmd.wb    = 1'b1;
          state_nxt = S_RB_GO;
        end
      end
      S_RB_GO: begin
        cmd.red_start = 1'b1;
        cmd.red_sel   = SEL_B;
        state_nxt     = S_RB_WAIT;
      end
      S_RB_WAIT: begin
        cmd.red_sel = SEL_B;
        if (sts.red_done) begin
          cmd.wb    = 1'b1;
          state_nxt = S_M0;
        end
      end
      // product issued one cycle, captured the next
      S_M0: begin
        cmd.mul_sel = MS_T0;
        state_nxt   = S_M1;
      end
      S_M1: begin
        cmd.mul_sel = MS_T1;
        cmd.cap     = CAP_T0;
        state_nxt   = S_M2;
      end
      S_M2: begin
        cmd.mul_sel = MS_DEN;
        cmd.cap     = CAP_T1;
        state_nxt   = S_M3;
      end
      S_M3: begin
        cmd.cap   = CAP_DEN;
        state_nxt = S_COMB;
      end
      S_COMB: begin
        cmd.comb  = 1'b1;
        state_nxt = S_RR_GO;
      end
      S_RR_GO: begin
        cmd.red_start = 1'b1;
        state_nxt     = S_RR_WAIT;
      end
      S_RR_WAIT: begin
        if (sts.red_done) begin
          cmd.wb    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      // hold until the result register is free
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered handshake output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

### sv/rational_add_sub_mul_reduce_top.sv
// Rational add, subtract and multiply with gcd reduction. One item at a time:
// an item is taken when in_tready is high, each operand is normalised (zero
// denominator read as one, denominator sign moved to the numerator) and
// reduced, the cross products are formed on one shared multiplier and the
// result is reduced again; a zero numerator is never reduced. Each of the
// three reductions has a start state, then binary gcd steps, then, unless
// the gcd is one, bit-serial division by the gcd, and a done state; a zero
// numerator goes straight from the start state to the done state. The
// result waits in an output register, so the next item is taken while it is
// still unread.
// depends on rasmr_pkg, rasmr_ctrl, rasmr_dp
`timescale 1ns / 1ps
`default_nettype none

module rational_add_sub_mul_reduce_top #(
  parameter int OPERAND_WIDTH = rasmr_pkg::OPERAND_WIDTH_DEF,
  localparam int IN_DATA_W = ((rasmr_pkg::OP_W + 4 * OPERAND_WIDTH + 7) / 8) * 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // operation, a_numerator, a_denominator, b_numerator, b_denominator
  input  wire logic [IN_DATA_W-1:0]              in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // result_numerator, result_denominator
  output logic [rasmr_pkg::OUT_DATA_W-1:0]       out_tdata
);

  import rasmr_pkg::*;

  localparam int W = OPERAND_WIDTH;

  cmd_t                  cmd;
  sts_t                  sts;
  logic signed [NUM_OUT_W-1:0] res_num;
  logic [DEN_OUT_W-1:0]        res_den;

  // controller
  rasmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath, fields unpacked from tdata
  rasmr_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .operation          (in_tdata[OP_W-1:0]),
    .a_numerator        (signed'(in_tdata[OP_W +: W])),
    .a_denominator      (signed'(in_tdata[OP_W + W +: W])),
    .b_numerator        (signed'(in_tdata[OP_W + 2 * W +: W])),
    .b_denominator      (signed'(in_tdata[OP_W + 3 * W +: W])),
    .result_numerator   (res_num),
    .result_denominator (res_den)
  );

  assign out_tdata = {res_den, res_num};

  // no new item is taken right after one was accepted
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while busy");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_tvalid || out_tready)
    else $error("result register overwritten");

  // denominator of a delivered result is never zero at widths that fit
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (OPERAND_WIDTH > 16) || (out_tdata[OUT_DATA_W-1:NUM_OUT_W] != '0))
    else $error("zero result denominator");

endmodule

`default_nettype wire
